### rtl/core/tlcd_pkg.sv
// ----------------------------------------------------------------------------
// tlcd_pkg
// Shared types, constants and lookup tables for the LCD text byte stream.
// ----------------------------------------------------------------------------
package tlcd_pkg;

   // Screen and table geometry
   localparam int GLYPH_COUNT    = 7;
   localparam int SCREEN_COLUMNS = 84;
   localparam int SCREEN_PAGES   = 6;
   localparam int STORED_GLYPHS  = 7;
   localparam int FONT_ROWS      = 92;
   localparam int FONT_FIRST     = 32;
   localparam int FONT_LAST      = 127;

   // Run sequencing
   localparam int STEP_W         = 5;
   localparam int GLYPH_HALF_LEN = 14;
   localparam int GLYPH_DATA_LEN = 24;

   // Controller command bytes
   localparam logic [7:0] CMD_EXTENDED = 8'h21;
   localparam logic [7:0] CMD_BASIC    = 8'h20;
   localparam logic [7:0] CMD_DISP_NRM = 8'h0C;
   localparam logic [7:0] CMD_SET_Y    = 8'h40;
   localparam logic [7:0] CMD_SET_X    = 8'h80;
   localparam logic [7:0] CMD_VOP      = 8'h80;
   localparam logic [7:0] CMD_TEMP     = 8'h04;
   localparam logic [7:0] CMD_BIAS     = 8'h10;

   typedef enum logic [2:0] {
      OP_CMD   = 3'd0,
      OP_DATA  = 3'd1,
      OP_POS   = 3'd2,
      OP_CHAR  = 3'd3,
      OP_GLYPH = 3'd4,
      OP_INIT  = 3'd5
   } opcode_type;

   typedef enum logic [1:0] {
      CSR_CONTRAST = 2'd0,
      CSR_TEMP     = 2'd1,
      CSR_BIAS     = 2'd2
   } csr_index_type;

   // Controller to datapath
   typedef struct packed {
      logic              load;
      logic              emit;
      logic              last;
      logic [STEP_W-1:0] step;
   } dp_cmd_type;

   // Bytes in the run of an item; zero for unused opcodes
   function automatic logic [STEP_W-1:0] run_length(input logic [2:0] op);
      logic [STEP_W-1:0] len;
      case (op)
         OP_CMD:   len = STEP_W'(1);
         OP_DATA:  len = STEP_W'(1);
         OP_POS:   len = STEP_W'(2);
         OP_CHAR:  len = STEP_W'(6);
         OP_GLYPH: len = STEP_W'(2 * GLYPH_HALF_LEN);
         OP_INIT:  len = STEP_W'(6);
         default:  len = '0;
      endcase
      return len;
   endfunction

   function automatic logic [6:0] clamp_col(input logic [6:0] c);
      return (int'(c) >= SCREEN_COLUMNS) ? 7'(SCREEN_COLUMNS - 1) : c;
   endfunction

   function automatic logic [2:0] clamp_page(input logic [3:0] p);
      return (int'(p) >= SCREEN_PAGES) ? 3'(SCREEN_PAGES - 1) : p[2:0];
   endfunction

   // 6x8 font, column 0 in the top byte
   function automatic logic [7:0] font_column(input logic [6:0] row,
                                              input logic [2:0] col);
      logic [47:0] bits;
      case (row)
         7'd0:  bits = 48'h000000000000;
         7'd1:  bits = 48'h0000002f0000;
         7'd2:  bits = 48'h000007000700;
         7'd3:  bits = 48'h00147f147f14;
         7'd4:  bits = 48'h00242a7f2a12;
         7'd5:  bits = 48'h006264081323;
         7'd6:  bits = 48'h003649552250;
         7'd7:  bits = 48'h000005030000;
         7'd8:  bits = 48'h00001c224100;
         7'd9:  bits = 48'h000041221c00;
         7'd10: bits = 48'h0014083e0814;
         7'd11: bits = 48'h0008083e0808;
         7'd12: bits = 48'h000000a06000;
         7'd13: bits = 48'h000808080808;
         7'd14: bits = 48'h000060600000;
         7'd15: bits = 48'h002010080402;
         7'd16: bits = 48'h003e5149453e;
         7'd17: bits = 48'h0000427f4000;
         7'd18: bits = 48'h004261514946;
         7'd19: bits = 48'h002141454b31;
         7'd20: bits = 48'h001814127f10;
         7'd21: bits = 48'h002745454539;
         7'd22: bits = 48'h003c4a494930;
         7'd23: bits = 48'h000171090503;
         7'd24: bits = 48'h003649494936;
         7'd25: bits = 48'h00064949291e;
         7'd26: bits = 48'h000036360000;
         7'd27: bits = 48'h000056360000;
         7'd28: bits = 48'h000814224100;
         7'd29: bits = 48'h001414141414;
         7'd30: bits = 48'h000041221408;
         7'd31: bits = 48'h000201510906;
         7'd32: bits = 48'h00324959513e;
         7'd33: bits = 48'h007c1211127c;
         7'd34: bits = 48'h007f49494936;
         7'd35: bits = 48'h003e41414122;
         7'd36: bits = 48'h007f4141221c;
         7'd37: bits = 48'h007f49494941;
         7'd38: bits = 48'h007f09090901;
         7'd39: bits = 48'h003e4149497a;
         7'd40: bits = 48'h007f0808087f;
         7'd41: bits = 48'h0000417f4100;
         7'd42: bits = 48'h002040413f01;
         7'd43: bits = 48'h007f08142241;
         7'd44: bits = 48'h007f40404040;
         7'd45: bits = 48'h007f020c027f;
         7'd46: bits = 48'h007f0408107f;
         7'd47: bits = 48'h003e4141413e;
         7'd48: bits = 48'h007f09090906;
         7'd49: bits = 48'h003e4151215e;
         7'd50: bits = 48'h007f09192946;
         7'd51: bits = 48'h004649494931;
         7'd52: bits = 48'h0001017f0101;
         7'd53: bits = 48'h003f4040403f;
         7'd54: bits = 48'h001f2040201f;
         7'd55: bits = 48'h003f4038403f;
         7'd56: bits = 48'h006314081463;
         7'd57: bits = 48'h000708700807;
         7'd58: bits = 48'h006151494543;
         7'd59: bits = 48'h00007f414100;
         7'd60: bits = 48'h00552a552a55;
         7'd61: bits = 48'h000041417f00;
         7'd62: bits = 48'h000402010204;
         7'd63: bits = 48'h004040404040;
         7'd64: bits = 48'h000001020400;
         7'd65: bits = 48'h002054545478;
         7'd66: bits = 48'h007f48444438;
         7'd67: bits = 48'h003844444420;
         7'd68: bits = 48'h00384444487f;
         7'd69: bits = 48'h003854545418;
         7'd70: bits = 48'h00087e090102;
         7'd71: bits = 48'h0018a4a4a47c;
         7'd72: bits = 48'h007f08040478;
         7'd73: bits = 48'h0000447d4000;
         7'd74: bits = 48'h004080847d00;
         7'd75: bits = 48'h007f10284400;
         7'd76: bits = 48'h0000417f4000;
         7'd77: bits = 48'h007c04180478;
         7'd78: bits = 48'h007c08040478;
         7'd79: bits = 48'h003844444438;
         7'd80: bits = 48'h00fc24242418;
         7'd81: bits = 48'h0018242418fc;
         7'd82: bits = 48'h007c08040408;
         7'd83: bits = 48'h004854545420;
         7'd84: bits = 48'h00043f444020;
         7'd85: bits = 48'h003c4040207c;
         7'd86: bits = 48'h001c2040201c;
         7'd87: bits = 48'h003c4030403c;
         7'd88: bits = 48'h004428102844;
         7'd89: bits = 48'h001ca0a0a07c;
         7'd90: bits = 48'h004464544c44;
         7'd91: bits = 48'h141414141414;
         default: bits = '0;
      endcase
      return bits[8 * (5 - int'(col)) +: 8];
   endfunction

   // 12x16 glyphs: top page bytes then bottom page bytes, byte 0 in the top
   function automatic logic [7:0] glyph_byte(input logic [2:0] g,
                                             input logic [STEP_W-1:0] j);
      logic [8*GLYPH_DATA_LEN-1:0] bits;
      case (g)
         3'd0: bits = {96'h1C0494D4B59694D494041C00, 96'h080A0A0A0A0F0A0A0A0A0800};
         3'd1: bits = {96'h00FC0484641F24C404FC0000, 96'h000F000000000008080F0000};
         3'd2: bits = {96'h224400C05FD555D55FC00000, 96'h0402090F080F080F080F0800};
         3'd3: bits = {96'h00FE0A8ABEAAABAABE8A0A00, 96'h08070008090A04040A090800};
         3'd4: bits = {96'h000010000000000000000000, 96'h000002000000000000000000};
         3'd5: bits = {96'h1122803E2AEA2AEA2A3E8000, 96'h04020809080F080F08090800};
         3'd6: bits = {96'h020502F804020202040E8000, 96'h000000000102020202010000};
         default: bits = '0;
      endcase
      return bits[8 * (GLYPH_DATA_LEN - 1 - int'(j)) +: 8];
   endfunction

endpackage

### rtl/core/text_to_lcd_byte_stream.sv
// ----------------------------------------------------------------------------
// text_to_lcd_byte_stream
// Turns display commands into a stream of LCD controller command/data bytes.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low. It then produces its
// run at one byte per cycle from the sequencer's step counter: 1 byte for a
// raw command or raw data item, 2 for set position, 6 for a character or
// init, 28 for a glyph; opcodes 6 and 7 are taken and produce nothing. busy
// rises the cycle after the item is taken and stays high through the final
// step of its run; an unused opcode leaves busy low. Each byte appears on
// the rsp_ ports in the cycle after its step, with rsp_valid high for that
// single cycle; the receiver cannot stall and must take every byte as it
// comes. rsp_last marks the final byte of a run. Write the csr_ registers
// only while busy is low and no byte is pending.
module text_to_lcd_byte_stream (
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   output logic       busy,
   input  logic [2:0] req_opcode,
   input  logic [7:0] req_value,
   input  logic [6:0] req_column,
   input  logic [2:0] req_page,
   input  logic [3:0] req_glyph_cell,
   output logic       rsp_valid,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_is_data,
   output logic       rsp_last,
   output logic       rsp_out_of_range,
   input  logic       csr_write,
   input  logic [1:0] csr_index,
   input  logic [6:0] csr_data
);

   tlcd_pkg::dp_cmd_type cmd;

   tlcd_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .req_opcode (req_opcode),
      .busy       (busy),
      .cmd        (cmd)
   );

   tlcd_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .req_opcode       (req_opcode),
      .req_value        (req_value),
      .req_column       (req_column),
      .req_page         (req_page),
      .req_glyph_cell   (req_glyph_cell),
      .csr_write        (csr_write),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .rsp_valid        (rsp_valid),
      .rsp_out_byte     (rsp_out_byte),
      .rsp_is_data      (rsp_is_data),
      .rsp_last         (rsp_last),
      .rsp_out_of_range (rsp_out_of_range)
   );

endmodule

### rtl/core/tlcd_ctrl.sv
// ----------------------------------------------------------------------------
// tlcd_ctrl
// Run sequencer: accepts an item, steps through its bytes, one per cycle.
// ----------------------------------------------------------------------------
module tlcd_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [2:0]            req_opcode,
   output logic                  busy,
   output tlcd_pkg::dp_cmd_type  cmd
);

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_RUN  = 2'b10
   } state_type;

   state_type                      state_ff, state_in;
   logic [tlcd_pkg::STEP_W-1:0]    step_ff, step_in;
   logic [tlcd_pkg::STEP_W-1:0]    final_ff, final_in;
   logic [tlcd_pkg::STEP_W-1:0]    len;
   logic                           accept;

   assign busy   = (state_ff == ST_RUN);
   assign accept = start && !busy;
   assign len    = tlcd_pkg::run_length(req_opcode);

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      final_in = final_ff;
      case (state_ff)
         ST_IDLE: begin
            // unused opcodes are taken but start no run
            if (accept && (len != '0)) begin
               state_in = ST_RUN;
               step_in  = '0;
               final_in = len - tlcd_pkg::STEP_W'(1);
            end
         end
         ST_RUN: begin
            if (step_ff == final_ff) begin
               state_in = ST_IDLE;
            end else begin
               step_in = step_ff + tlcd_pkg::STEP_W'(1);
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= '0;
         final_ff <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
         final_ff <= final_in;
      end
   end

   assign cmd.load = accept;
   assign cmd.emit = busy;
   assign cmd.last = busy && (step_ff == final_ff);
   assign cmd.step = step_ff;

   a_empty_run_stays_idle: assert property (@(posedge clock) disable iff (reset)
      (accept && (len == '0)) |=> !busy)
      else $error("unused opcode started a run");

   a_last_only_in_run: assert property (@(posedge clock) disable iff (reset)
      cmd.last |-> cmd.emit)
      else $error("last marked outside a run");

   a_step_advances: assert property (@(posedge clock) disable iff (reset)
      (cmd.emit && !cmd.last) |=>
         (cmd.emit && (cmd.step == $past(cmd.step) + tlcd_pkg::STEP_W'(1))))
      else $error("run step did not advance");

   a_run_ends_after_last: assert property (@(posedge clock) disable iff (reset)
      (cmd.emit && cmd.last) |=> !cmd.emit)
      else $error("run continued past its last byte");

endmodule

### rtl/core/tlcd_datapath.sv
// ----------------------------------------------------------------------------
// tlcd_datapath
// Item fields, setup registers, byte selection and the output register.
// ----------------------------------------------------------------------------
module tlcd_datapath (
   input  logic                  clock,
   input  logic                  reset,
   input  tlcd_pkg::dp_cmd_type  cmd,
   input  logic [2:0]            req_opcode,
   input  logic [7:0]            req_value,
   input  logic [6:0]            req_column,
   input  logic [2:0]            req_page,
   input  logic [3:0]            req_glyph_cell,
   input  logic                  csr_write,
   input  logic [1:0]            csr_index,
   input  logic [6:0]            csr_data,
   output logic                  rsp_valid,
   output logic [7:0]            rsp_out_byte,
   output logic                  rsp_is_data,
   output logic                  rsp_last,
   output logic                  rsp_out_of_range
);

   // setup registers
   logic [6:0] contrast_ff;
   logic [1:0] temp_ff;
   logic [2:0] bias_ff;

   // latched item
   logic [2:0] op_ff,    op_in;
   logic [7:0] val_ff,   val_in;
   logic [6:0] col_ff,   col_in;
   logic [2:0] page_ff,  page_in;
   logic [2:0] page2_ff, page2_in;
   logic       flag_ff,  flag_in;
   logic       have_ff,  have_in;
   logic [6:0] row_ff,   row_in;
   logic [2:0] glyph_ff, glyph_in;

   // output register
   logic       valid_ff;
   logic [7:0] byte_ff,  byte_in;
   logic       data_ff,  data_in;
   logic       last_ff;
   logic       oor_ff;

   logic                        half;
   logic [tlcd_pkg::STEP_W-1:0] local_step;
   logic [tlcd_pkg::STEP_W-1:0] glyph_idx;
   logic [6:0]                  cell_col;

   always_ff @(posedge clock) begin
      if (reset) begin
         contrast_ff <= 7'd70;
         temp_ff     <= 2'd2;
         bias_ff     <= 3'd3;
      end else if (csr_write) begin
         case (csr_index)
            tlcd_pkg::CSR_CONTRAST: contrast_ff <= csr_data;
            tlcd_pkg::CSR_TEMP:     temp_ff     <= csr_data[1:0];
            tlcd_pkg::CSR_BIAS:     bias_ff     <= csr_data[2:0];
            default: begin
            end
         endcase
      end
   end

   assign cell_col = 7'(req_glyph_cell) * 7'd6;

   // decode the item once at acceptance
   always_comb begin
      op_in    = req_opcode;
      val_in   = req_value;
      page_in  = tlcd_pkg::clamp_page({1'b0, req_page});
      page2_in = tlcd_pkg::clamp_page(4'(req_page) + 4'd1);
      row_in   = 7'(req_value - 8'(tlcd_pkg::FONT_FIRST));
      glyph_in = req_value[2:0];
      col_in   = tlcd_pkg::clamp_col(req_column);
      flag_in  = 1'b0;
      have_in  = 1'b0;
      case (req_opcode)
         tlcd_pkg::OP_CHAR: begin
            flag_in = (int'(req_value) < tlcd_pkg::FONT_FIRST) ||
                      (int'(req_value) > tlcd_pkg::FONT_LAST);
            have_in = (int'(req_value) >= tlcd_pkg::FONT_FIRST) &&
                      (int'(req_value) < tlcd_pkg::FONT_FIRST + tlcd_pkg::FONT_ROWS);
         end
         tlcd_pkg::OP_GLYPH: begin
            col_in  = tlcd_pkg::clamp_col(cell_col);
            flag_in = (int'(req_value) >= tlcd_pkg::GLYPH_COUNT);
            have_in = (int'(req_value) < tlcd_pkg::GLYPH_COUNT) &&
                      (int'(req_value) < tlcd_pkg::STORED_GLYPHS);
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff    <= op_in;
         val_ff   <= val_in;
         col_ff   <= col_in;
         page_ff  <= page_in;
         page2_ff <= page2_in;
         flag_ff  <= flag_in;
         have_ff  <= have_in;
         row_ff   <= row_in;
         glyph_ff <= glyph_in;
      end
   end

   // a glyph run is two halves: position pair then twelve data bytes
   assign half       = (int'(cmd.step) >= tlcd_pkg::GLYPH_HALF_LEN);
   assign local_step = half ? cmd.step - tlcd_pkg::STEP_W'(tlcd_pkg::GLYPH_HALF_LEN)
                            : cmd.step;
   assign glyph_idx  = half ? cmd.step - tlcd_pkg::STEP_W'(4)
                            : cmd.step - tlcd_pkg::STEP_W'(2);

   always_comb begin
      byte_in = '0;
      data_in = 1'b0;
      case (op_ff)
         tlcd_pkg::OP_CMD: begin
            byte_in = val_ff;
         end
         tlcd_pkg::OP_DATA: begin
            byte_in = val_ff;
            data_in = 1'b1;
         end
         tlcd_pkg::OP_POS: begin
            if (cmd.step == '0) begin
               byte_in = tlcd_pkg::CMD_SET_Y | {5'b0, page_ff};
            end else begin
               byte_in = tlcd_pkg::CMD_SET_X | {1'b0, col_ff};
            end
         end
         tlcd_pkg::OP_CHAR: begin
            data_in = 1'b1;
            byte_in = have_ff ? tlcd_pkg::font_column(row_ff, cmd.step[2:0]) : 8'h00;
         end
         tlcd_pkg::OP_GLYPH: begin
            if (local_step == '0) begin
               byte_in = tlcd_pkg::CMD_SET_Y | {5'b0, (half ? page2_ff : page_ff)};
            end else if (local_step == tlcd_pkg::STEP_W'(1)) begin
               byte_in = tlcd_pkg::CMD_SET_X | {1'b0, col_ff};
            end else begin
               data_in = 1'b1;
               byte_in = have_ff ? tlcd_pkg::glyph_byte(glyph_ff, glyph_idx) : 8'h00;
            end
         end
         tlcd_pkg::OP_INIT: begin
            case (cmd.step[2:0])
               3'd0:    byte_in = tlcd_pkg::CMD_EXTENDED;
               3'd1:    byte_in = tlcd_pkg::CMD_VOP | {1'b0, contrast_ff};
               3'd2:    byte_in = tlcd_pkg::CMD_TEMP | {6'b0, temp_ff};
               3'd3:    byte_in = tlcd_pkg::CMD_BIAS | {5'b0, bias_ff};
               3'd4:    byte_in = tlcd_pkg::CMD_BASIC;
               default: byte_in = tlcd_pkg::CMD_DISP_NRM;
            endcase
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= cmd.emit;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         byte_ff <= byte_in;
         data_ff <= data_in;
         last_ff <= cmd.last;
         oor_ff  <= flag_ff;
      end
   end

   assign rsp_valid        = valid_ff;
   assign rsp_out_byte     = byte_ff;
   assign rsp_is_data      = data_ff;
   assign rsp_last         = last_ff;
   assign rsp_out_of_range = oor_ff;

endmodule
